// ----- design/sacl_pkg.sv -----
// Shared types, constants and helpers for the set-associative LRU cache simulator.
// Used by sacl_way_scan and set_assoc_lru_cache_sim; depends on nothing else.
package sacl_pkg;

    localparam int STAMP_W    = 64;
    localparam int TOTAL_W    = 32;
    localparam int OUTCOME_W  = 2;
    localparam int WAY_OUT_W  = 3;
    localparam int OUT_DATA_W = 104;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 4;

    typedef logic [OUTCOME_W-1:0]   outcome_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam outcome_t OUTCOME_HIT   = 2'd0;
    localparam outcome_t OUTCOME_FILL  = 2'd1;
    localparam outcome_t OUTCOME_EVICT = 2'd2;

    localparam cfg_index_t REG_SET_BITS   = 2'd0;
    localparam cfg_index_t REG_WAYS       = 2'd1;
    localparam cfg_index_t REG_BLOCK_BITS = 2'd2;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef struct packed {
        logic hit;
        logic free;
    } scan_flags_t;

    function automatic logic [TOTAL_W-1:0] bump(input logic [TOTAL_W-1:0] v);
        bump = (v == TOTAL_MAX) ? v : v + TOTAL_W'(1);
    endfunction

endpackage

// ----- design/sacl_line_ram.sv -----
// Line store of the cache simulator: one write port and one registered read port.
// Generic memory; depends on no package.
module sacl_line_ram #(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9,
    parameter int DATA_W = 113
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/sacl_way_scan.sv -----
// Shared compare unit that looks at one way per cycle while step is high and keeps the first hit,
// the first empty way and the oldest valid way of the set. Uses sacl_pkg.
module sacl_way_scan #(
    parameter int WAY_W = 3,
    parameter int TAG_W = 48
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic                       step,
    input  logic [WAY_W-1:0]           step_way,
    input  logic                       line_valid,
    input  logic [TAG_W-1:0]           line_tag,
    input  logic [sacl_pkg::STAMP_W-1:0] line_stamp,
    input  logic [TAG_W-1:0]           tag,
    output sacl_pkg::scan_flags_t      flags,
    output logic [WAY_W-1:0]           hit_way,
    output logic [WAY_W-1:0]           free_way,
    output logic [WAY_W-1:0]           old_way
);

    logic                         hit_found_reg;
    logic                         free_found_reg;
    logic                         have_old_reg;
    logic [WAY_W-1:0]             hit_way_reg;
    logic [WAY_W-1:0]             free_way_reg;
    logic [WAY_W-1:0]             old_way_reg;
    logic [sacl_pkg::STAMP_W-1:0] old_stamp_reg;
    logic                         take_hit;
    logic                         take_free;
    logic                         take_old;

    assign take_hit  = step && line_valid && (line_tag == tag) && !hit_found_reg;
    assign take_free = step && !line_valid && !free_found_reg;
    assign take_old  = step && line_valid && (!have_old_reg || (line_stamp < old_stamp_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            have_old_reg   <= 1'b0;
        end else if (start) begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            have_old_reg   <= 1'b0;
        end else begin
            if (take_hit) begin
                hit_found_reg <= 1'b1;
            end
            if (take_free) begin
                free_found_reg <= 1'b1;
            end
            if (take_old) begin
                have_old_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_hit) begin
            hit_way_reg <= step_way;
        end
        if (take_free) begin
            free_way_reg <= step_way;
        end
        if (take_old) begin
            old_way_reg   <= step_way;
            old_stamp_reg <= line_stamp;
        end
    end

    assign flags.hit  = hit_found_reg;
    assign flags.free = free_found_reg;
    assign hit_way    = hit_way_reg;
    assign free_way   = free_way_reg;
    assign old_way    = old_way_reg;

endmodule

// ----- design/set_assoc_lru_cache_sim.sv -----
// Set-associative LRU cache simulator, tags only. An accepted address goes
// through setup, a scan that reads each way in use from the line store, and an
// update that writes the chosen line and registers the result; the update waits
// while the sink still holds the last result. A new address is taken only in
// idle. After reset a clearing pass empties all 2^MAX_SET_BITS * MAX_WAYS lines
// (512 by default) before the first address is taken. Uses sacl_pkg.
module set_assoc_lru_cache_sim #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_WIDTH   = 48
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // address
    input  logic [((ADDR_WIDTH+7)/8)*8-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // outcome, way_used, hit_total, miss_total, evict_total
    output logic [sacl_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sacl_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int LINES  = (1 << MAX_SET_BITS) * MAX_WAYS;
    localparam int LINE_W = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int NW_W   = $clog2(MAX_WAYS + 1);
    localparam int SH_W   = $clog2(MAX_SET_BITS + 16);
    localparam int DATA_W = 1 + ADDR_WIDTH + sacl_pkg::STAMP_W;
    localparam int PAD_W  = sacl_pkg::OUT_DATA_W - sacl_pkg::OUTCOME_W
                            - sacl_pkg::WAY_OUT_W - 3 * sacl_pkg::TOTAL_W;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SETUP  = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_UPDATE = 3'd4;

    logic [2:0]                   state_reg, state_next;
    logic [LINE_W-1:0]            clr_addr_reg;
    logic [2:0]                   set_bits_reg;
    logic [3:0]                   ways_reg;
    logic [3:0]                   block_bits_reg;
    logic [ADDR_WIDTH-1:0]        addr_reg;
    logic [SET_W-1:0]             set_reg;
    logic [ADDR_WIDTH-1:0]        tag_reg;
    logic [NW_W-1:0]              issue_cnt_reg;
    logic                         pipe_valid_reg;
    logic                         pipe_last_reg;
    logic [WAY_W-1:0]             pipe_way_reg;
    logic [sacl_pkg::STAMP_W-1:0] access_count_reg;
    logic [sacl_pkg::TOTAL_W-1:0] hits_reg;
    logic [sacl_pkg::TOTAL_W-1:0] misses_reg;
    logic [sacl_pkg::TOTAL_W-1:0] evicts_reg;
    logic                         m_tvalid_reg;
    logic [sacl_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    logic [SH_W-1:0]              sb_eff;
    logic [NW_W-1:0]              nw_eff;
    logic [SET_W-1:0]             set_mask;
    logic [ADDR_WIDTH-1:0]        addr_shifted;
    logic [LINE_W-1:0]            base_addr;
    logic                         rd_en;
    logic [LINE_W-1:0]            rd_addr;
    logic [DATA_W-1:0]            rd_data;
    logic                         wr_en;
    logic [LINE_W-1:0]            wr_addr;
    logic [DATA_W-1:0]            wr_data;
    logic                         scan_start;
    sacl_pkg::scan_flags_t        flags;
    logic [WAY_W-1:0]             hit_way;
    logic [WAY_W-1:0]             free_way;
    logic [WAY_W-1:0]             old_way;
    logic [WAY_W-1:0]             chosen_way;
    sacl_pkg::outcome_t           outcome;
    logic                         load;
    logic [sacl_pkg::STAMP_W-1:0] access_count_next;
    logic [sacl_pkg::TOTAL_W-1:0] hits_next;
    logic [sacl_pkg::TOTAL_W-1:0] misses_next;
    logic [sacl_pkg::TOTAL_W-1:0] evicts_next;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_bits_reg   <= 3'd4;
            ways_reg       <= 4'd1;
            block_bits_reg <= 4'd4;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                sacl_pkg::REG_SET_BITS:   set_bits_reg   <= cfg_data[2:0];
                sacl_pkg::REG_WAYS:       ways_reg       <= cfg_data[3:0];
                sacl_pkg::REG_BLOCK_BITS: block_bits_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        sb_eff = (set_bits_reg > MAX_SET_BITS) ? SH_W'(MAX_SET_BITS) : SH_W'(set_bits_reg);
        priority if (ways_reg == 4'd0) begin
            nw_eff = NW_W'(1);
        end else if (ways_reg > MAX_WAYS) begin
            nw_eff = NW_W'(MAX_WAYS);
        end else begin
            nw_eff = NW_W'(ways_reg);
        end
        set_mask     = ~({SET_W{1'b1}} << sb_eff);
        addr_shifted = addr_reg >> block_bits_reg;
        base_addr    = LINE_W'(LINE_W'(set_reg) * LINE_W'(MAX_WAYS));
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            addr_reg <= s_tdata[ADDR_WIDTH-1:0];
        end
        if (state_reg == ST_SETUP) begin
            set_reg <= SET_W'(addr_shifted) & set_mask;
            tag_reg <= addr_reg >> (sb_eff + SH_W'(block_bits_reg));
        end
    end

    assign rd_en   = (state_reg == ST_SCAN) && (issue_cnt_reg < nw_eff);
    assign rd_addr = base_addr + LINE_W'(issue_cnt_reg[WAY_W-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_cnt_reg  <= '0;
            pipe_valid_reg <= 1'b0;
        end else if (state_reg == ST_SETUP) begin
            issue_cnt_reg  <= '0;
            pipe_valid_reg <= 1'b0;
        end else begin
            pipe_valid_reg <= rd_en;
            if (rd_en) begin
                issue_cnt_reg <= issue_cnt_reg + NW_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        pipe_way_reg  <= issue_cnt_reg[WAY_W-1:0];
        pipe_last_reg <= (issue_cnt_reg == nw_eff - NW_W'(1));
    end

    assign scan_start = (state_reg == ST_SETUP);

    sacl_way_scan #(
        .WAY_W (WAY_W),
        .TAG_W (ADDR_WIDTH)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (scan_start),
        .step       (pipe_valid_reg),
        .step_way   (pipe_way_reg),
        .line_valid (rd_data[DATA_W-1]),
        .line_tag   (rd_data[DATA_W-2:sacl_pkg::STAMP_W]),
        .line_stamp (rd_data[sacl_pkg::STAMP_W-1:0]),
        .tag        (tag_reg),
        .flags      (flags),
        .hit_way    (hit_way),
        .free_way   (free_way),
        .old_way    (old_way)
    );

    always_comb begin
        priority if (flags.hit) begin
            chosen_way = hit_way;
            outcome    = sacl_pkg::OUTCOME_HIT;
        end else if (flags.free) begin
            chosen_way = free_way;
            outcome    = sacl_pkg::OUTCOME_FILL;
        end else begin
            chosen_way = old_way;
            outcome    = sacl_pkg::OUTCOME_EVICT;
        end
    end

    assign load = (state_reg == ST_UPDATE) && (!m_tvalid_reg || m_tready);
    assign access_count_next = access_count_reg + sacl_pkg::STAMP_W'(1);
    assign hits_next   = flags.hit ? sacl_pkg::bump(hits_reg) : hits_reg;
    assign misses_next = flags.hit ? misses_reg : sacl_pkg::bump(misses_reg);
    assign evicts_next = (outcome == sacl_pkg::OUTCOME_EVICT) ? sacl_pkg::bump(evicts_reg)
                                                              : evicts_reg;

    always_comb begin
        if (state_reg == ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end else begin
            wr_en   = load;
            wr_addr = base_addr + LINE_W'(chosen_way);
            wr_data = {1'b1, tag_reg, access_count_next};
        end
    end

    sacl_line_ram #(
        .DEPTH  (LINES),
        .ADDR_W (LINE_W),
        .DATA_W (DATA_W)
    ) u_lines (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == LINE_W'(LINES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: state_next = ST_SCAN;
            ST_SCAN: begin
                if (pipe_valid_reg && pipe_last_reg) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + LINE_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            access_count_reg <= '0;
            hits_reg         <= '0;
            misses_reg       <= '0;
            evicts_reg       <= '0;
            m_tvalid_reg     <= 1'b0;
        end else if (load) begin
            access_count_reg <= access_count_next;
            hits_reg         <= hits_next;
            misses_reg       <= misses_next;
            evicts_reg       <= evicts_next;
            m_tvalid_reg     <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= {{PAD_W{1'b0}}, evicts_next, misses_next, hits_next,
                            sacl_pkg::WAY_OUT_W'(chosen_way), outcome};
        end
    end

    // The line store is being cleared, so no address may be taken.
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("address accepted during clearing pass");

    // A result held back by the sink keeps the update waiting.
    a_update_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPDATE && m_tvalid_reg && !m_tready)
        |=> (state_reg == ST_UPDATE && m_tvalid_reg))
        else $error("pending result overwritten");

    // Every miss moves the miss total unless it is saturated.
    a_miss_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && !flags.hit)
        |=> (m_tdata[68:37] == $past(misses_reg) + 32'd1)
            || ($past(misses_reg) == sacl_pkg::TOTAL_MAX))
        else $error("miss not counted");

endmodule

// ----- bench/set_assoc_lru_cache_sim_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for set_assoc_lru_cache_sim: drives address and geometry transfers,
// predicts the outcome of every access and compares each result transfer with it.
// Depends on sacl_pkg and the set_assoc_lru_cache_sim RTL.
module set_assoc_lru_cache_sim_tb;

    localparam int MAX_SET_BITS = 6;
    localparam int MAX_WAYS     = 8;
    localparam int ADDR_W       = 48;
    localparam int LINES        = (1 << MAX_SET_BITS) * MAX_WAYS;
    localparam int HOLD_CYCLES  = 400;
    localparam int BATCH_ITEMS  = 200;
    localparam int REPORT_LIMIT = 10;

    typedef logic [ADDR_W-1:0] addr_t;

    typedef struct packed {
        sacl_pkg::outcome_t             outcome;
        logic [sacl_pkg::WAY_OUT_W-1:0] way;
        logic [sacl_pkg::TOTAL_W-1:0]   hits;
        logic [sacl_pkg::TOTAL_W-1:0]   misses;
        logic [sacl_pkg::TOTAL_W-1:0]   evicts;
    } access_result_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [ADDR_W-1:0]               s_tdata   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [sacl_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    sacl_pkg::cfg_index_t            cfg_index = sacl_pkg::REG_SET_BITS;
    logic [sacl_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // Cache image kept by the bench.
    bit                            line_live [LINES];
    addr_t                         line_tags [LINES];
    logic [sacl_pkg::STAMP_W-1:0]  line_age  [LINES];
    logic [sacl_pkg::STAMP_W-1:0]  access_seq     = '0;
    logic [sacl_pkg::TOTAL_W-1:0]  hit_count      = '0;
    logic [sacl_pkg::TOTAL_W-1:0]  miss_count     = '0;
    logic [sacl_pkg::TOTAL_W-1:0]  evict_count    = '0;
    logic [2:0]                    reg_set_bits   = 3'd4;
    logic [3:0]                    reg_ways       = 4'd1;
    logic [3:0]                    reg_block_bits = 4'd4;

    access_result_t pending_results[$];
    int send_idle_pct   = 9;
    int recv_idle_pct   = 81;
    int hold_requests   = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int error_count     = 0;
    int hits_seen       = 0;
    int fills_seen      = 0;
    int evicts_seen     = 0;
    int geometries_used = 1;

    set_assoc_lru_cache_sim #(
        .MAX_SET_BITS(MAX_SET_BITS),
        .MAX_WAYS    (MAX_WAYS),
        .ADDR_WIDTH  (ADDR_W)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // address
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // outcome, way_used, hit_total, miss_total, evict_total
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("set_assoc_lru_cache_sim verification failed");
        $finish;
    end

    function automatic int eff_set_bits();
        return (reg_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(reg_set_bits);
    endfunction

    function automatic int eff_ways();
        if (reg_ways == 4'd0) begin
            return 1;
        end
        return (reg_ways > MAX_WAYS) ? MAX_WAYS : int'(reg_ways);
    endfunction

    function automatic logic [sacl_pkg::TOTAL_W-1:0] sat_inc(
        input logic [sacl_pkg::TOTAL_W-1:0] v);
        return (v == '1) ? v : v + sacl_pkg::TOTAL_W'(1);
    endfunction

    function automatic addr_t rand_addr();
        return addr_t'({$urandom(), $urandom()});
    endfunction

    function automatic addr_t build_addr(input addr_t tag, input int set_idx,
                                         input addr_t offset);
        int sb;
        int bb;
        sb = eff_set_bits();
        bb = int'(reg_block_bits);
        return (tag << (sb + bb)) | (addr_t'(set_idx) << bb)
             | (offset & ((addr_t'(1) << bb) - addr_t'(1)));
    endfunction

    // Looks up one access in the cache image, updates it and returns the result.
    function automatic access_result_t predict_access(input addr_t addr);
        access_result_t r;
        int sb;
        int nw;
        int bb;
        int base;
        int way;
        int i;
        addr_t set_idx;
        addr_t tag;
        logic [sacl_pkg::STAMP_W-1:0] oldest;
        bit found;
        sb = eff_set_bits();
        nw = eff_ways();
        bb = int'(reg_block_bits);
        set_idx = (addr >> bb) & ((addr_t'(1) << sb) - addr_t'(1));
        tag = addr >> (sb + bb);
        base = int'(set_idx) * MAX_WAYS;
        way = 0;
        found = 1'b0;
        access_seq = access_seq + sacl_pkg::STAMP_W'(1);
        for (i = 0; i < nw && !found; i++) begin
            if (line_live[base + i] && line_tags[base + i] == tag) begin
                way = i;
                found = 1'b1;
            end
        end
        if (found) begin
            r.outcome = sacl_pkg::OUTCOME_HIT;
            hit_count = sat_inc(hit_count);
        end else begin
            miss_count = sat_inc(miss_count);
            for (i = 0; i < nw && !found; i++) begin
                if (!line_live[base + i]) begin
                    way = i;
                    found = 1'b1;
                end
            end
            if (found) begin
                r.outcome = sacl_pkg::OUTCOME_FILL;
            end else begin
                oldest = line_age[base];
                way = 0;
                for (i = 1; i < nw; i++) begin
                    if (line_age[base + i] < oldest) begin
                        oldest = line_age[base + i];
                        way = i;
                    end
                end
                r.outcome = sacl_pkg::OUTCOME_EVICT;
                evict_count = sat_inc(evict_count);
            end
        end
        line_live[base + way] = 1'b1;
        line_tags[base + way] = tag;
        line_age[base + way] = access_seq;
        r.way = sacl_pkg::WAY_OUT_W'(way);
        r.hits = hit_count;
        r.misses = miss_count;
        r.evicts = evict_count;
        return r;
    endfunction

    // Result side: checks every result transfer.
    initial begin : result_checker
        access_result_t got;
        access_result_t want;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got.outcome = m_tdata[1:0];
                got.way = m_tdata[4:2];
                got.hits = m_tdata[36:5];
                got.misses = m_tdata[68:37];
                got.evicts = m_tdata[100:69];
                if (pending_results.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT) begin
                        $display("ERROR: result transfer with no access pending: %h", m_tdata);
                    end
                end else begin
                    want = pending_results.pop_front();
                    results_checked++;
                    case (want.outcome)
                        sacl_pkg::OUTCOME_HIT:  hits_seen++;
                        sacl_pkg::OUTCOME_FILL: fills_seen++;
                        default:                evicts_seen++;
                    endcase
                    if (got != want) begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT) begin
                            $display("ERROR: result %0d expected outcome %0d way %0d %0d/%0d/%0d",
                                     results_checked, want.outcome, want.way,
                                     want.hits, want.misses, want.evicts);
                            $display("       got outcome %0d way %0d %0d/%0d/%0d",
                                     got.outcome, got.way, got.hits, got.misses, got.evicts);
                        end
                    end
                end
            end
        end
    end

    // Result side: paces m_tready and counts out the long holds.
    initial begin : ready_driver
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge aclk);
            if (hold_requests != hold_seen) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= (int'($urandom_range(99)) >= recv_idle_pct);
            end
        end
    end

    task automatic send_access(input addr_t addr);
        while (int'($urandom_range(99)) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= addr;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(predict_access(addr));
        items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (MAX_WAYS + 8) @(posedge aclk);
    endtask

    task automatic write_reg(input sacl_pkg::cfg_index_t idx,
                             input logic [sacl_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            sacl_pkg::REG_SET_BITS:   reg_set_bits = value[2:0];
            sacl_pkg::REG_WAYS:       reg_ways = value;
            sacl_pkg::REG_BLOCK_BITS: reg_block_bits = value;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_geometry(input logic [3:0] sb, input logic [3:0] nw,
                                input logic [3:0] bb);
        wait_drained();
        write_reg(sacl_pkg::REG_SET_BITS, sb);
        write_reg(sacl_pkg::REG_WAYS, nw);
        write_reg(sacl_pkg::REG_BLOCK_BITS, bb);
        geometries_used++;
    endtask

    // Mostly accesses from a small tag pool over a few sets, so that hits,
    // fills and evictions all occur; the rest are fully random addresses.
    task automatic run_random_batch(input int count);
        addr_t tag_pool[MAX_WAYS + 2];
        addr_t offset;
        int pool_n;
        int set_span;
        int k;
        pool_n = eff_ways() + 2;
        set_span = ((1 << eff_set_bits()) < 4) ? (1 << eff_set_bits()) : 4;
        foreach (tag_pool[j]) begin
            tag_pool[j] = rand_addr();
        end
        for (k = 0; k < count; k++) begin
            if ($urandom_range(99) < 15) begin
                send_access(rand_addr());
            end else begin
                if ($urandom_range(99) < 5) begin
                    tag_pool[$urandom_range(pool_n - 1)] = rand_addr();
                end
                offset = rand_addr();
                send_access(build_addr(tag_pool[$urandom_range(pool_n - 1)],
                                       int'($urandom_range(set_span - 1)), offset));
            end
        end
    endtask

    task automatic test_default_geometry();
        send_access('0);
        send_access('1);
        send_access('0);
        send_access(48'h0000_0000_000F);
        send_access(48'h0000_0000_0100);
        send_access('0);
        send_access(48'hFFFF_FFFF_FFF0);
    endtask

    task automatic test_lru_order();
        set_geometry(4'd0, 4'd2, 4'd0);
        send_access(48'h5);
        send_access(48'h6);
        send_access(48'h5);
        send_access(48'h7);
        send_access(48'h6);
        send_access(48'h5);
    endtask

    task automatic test_wide_geometry();
        int i;
        set_geometry(4'hF, 4'hF, 4'hF);
        for (i = 0; i < MAX_WAYS + 1; i++) begin
            send_access(build_addr(addr_t'(i + 1), (1 << MAX_SET_BITS) - 1, '1));
        end
        send_access(build_addr(addr_t'(4), (1 << MAX_SET_BITS) - 1, '0));
        set_geometry(4'd0, 4'd0, 4'd0);
        send_access(48'h1);
        send_access(48'h1);
    endtask

    task automatic test_random_traffic();
        int sb_tab[9] = '{6, 0, 10, 1, 3, 15, 5, 4, 14};
        int nw_tab[9] = '{8, 1, 4, 0, 2, 9, 15, 3, 5};
        int bb_tab[9] = '{12, 0, 3, 15, 6, 5, 0, 2, 8};
        int mode;
        int k;
        for (mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 9 : ((mode == 1) ? 81 : 0);
            recv_idle_pct = (mode == 0) ? 81 : ((mode == 1) ? 9 : 0);
            for (k = 0; k < 3; k++) begin
                set_geometry(4'(sb_tab[mode * 3 + k]), 4'(nw_tab[mode * 3 + k]),
                             4'(bb_tab[mode * 3 + k]));
                run_random_batch(BATCH_ITEMS);
            end
        end
    endtask

    task automatic test_backpressure();
        set_geometry(4'd2, 4'd4, 4'd6);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests++;
        run_random_batch(40);
        wait_drained();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_geometry();
        test_lru_order();
        test_wide_geometry();
        test_random_traffic();
        test_backpressure();
        $display("Checked %0d results for %0d accesses over %0d cache geometries.",
                 results_checked, items_sent, geometries_used);
        $display("Predicted %0d hits, %0d fills and %0d evictions.",
                 hits_seen, fills_seen, evicts_seen);
        if (error_count == 0) begin
            $display("set_assoc_lru_cache_sim verification clean");
        end else begin
            $display("set_assoc_lru_cache_sim verification failed");
        end
        $finish;
    end

endmodule
